FILE: design/gvc_pkg.sv
`default_nettype none
package gvc_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_EDGES_DEF    = 256;

	localparam int VERT_W   = 6;
	localparam int VCOUNT_W = 7;
	localparam int EDGE_W   = 2 * VERT_W;
	localparam int MASK_W   = 64;
	localparam int S_DATA_W = 16;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam int VCOUNT_RST = 64;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_ADD   = 2'd0;
	localparam cmd_t CMD_COVER = 2'd1;
	localparam cmd_t CMD_CLEAR = 2'd2;

	typedef enum logic [1:0] {
		ST_ACCEPT  = 2'd0,
		ST_REJECT  = 2'd1,
		ST_COVER   = 2'd2,
		ST_CLEARED = 2'd3
	} status_t;

endpackage
`default_nettype wire

FILE: design/greedy_vertex_cover.sv
// Greedy two-approximation vertex cover. Edges arrive on the slave stream with
// cmd 0 in tuser and are appended to an internal edge store; each add answers
// at once with accepted or rejected (endpoint at or above the vertex limit,
// or store full). Cmd 2 empties the store, and any other cmd answers rejected.
// Add and clear transfers are taken one per cycle while no result waits
// stalled on the master stream. Cmd 1 computes the cover: vertices 0 to
// limit-1 are visited in order, a marked vertex is skipped, and an unmarked
// one streams the stored edges from the single read port of the edge store,
// one per cycle, until a free neighbor is found or the edges run out. No
// input is taken while a cover is computed. The vertex limit is the
// vertex_count register at APB address 0, capped at MAX_VERTICES. The cover
// comes back as a 64-bit mask with status cover ready.
`default_nettype none
module greedy_vertex_cover #(
	parameter int MAX_VERTICES = gvc_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = gvc_pkg::MAX_EDGES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output      logic                          s_tready,
	input  wire logic [gvc_pkg::S_DATA_W-1:0]  s_tdata,  // vertex_a, vertex_b, zero pad
	input  wire logic [1:0]                    s_tuser,  // cmd
	output      logic                          m_tvalid,
	input  wire logic                          m_tready,
	output      logic [gvc_pkg::MASK_W-1:0]    m_tdata,  // cover_mask
	output      logic [1:0]                    m_tuser,  // status
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [gvc_pkg::APB_AW-1:0]    paddr,
	input  wire logic [gvc_pkg::APB_DW-1:0]    pwdata,
	output      logic [gvc_pkg::APB_DW-1:0]    prdata,
	output      logic                          pready
);
	import gvc_pkg::*;

	localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_EDGES);
	localparam logic [VCOUNT_W-1:0] VMAX = VCOUNT_W'(MAX_VERTICES);

	typedef enum logic [1:0] {S_IDLE, S_VCHK, S_SCAN} state_t;

	state_t                 state_q;
	logic [VCOUNT_W-1:0]    vcount_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          e_q;
	logic [VCOUNT_W-1:0]    u_q;
	logic [MASK_W-1:0]      marked_q;
	logic                   rd_vld_s1;
	logic [EDGE_W-1:0]      rd_s1;
	logic [EDGE_W-1:0]      mem [MAX_EDGES];
	logic                   m_tvalid_q;
	logic [MASK_W-1:0]      m_tdata_q;
	status_t                m_tuser_q;

	logic [VCOUNT_W-1:0]    lim;
	logic                   accept;
	logic [VERT_W-1:0]      in_a, in_b;
	logic                   add_ok;
	logic                   mem_we;
	logic [CW-1:0]          rd_addr;
	logic [VERT_W-1:0]      ea, eb;
	logic                   e_rng, take_b, take_a;
	logic [VERT_W-1:0]      nbr;
	logic                   cfg_we;

	assign lim    = (vcount_q > VMAX) ? VMAX : vcount_q;
	assign s_tready = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign accept = s_tvalid && s_tready;
	assign in_a   = s_tdata[VERT_W-1:0];
	assign in_b   = s_tdata[EDGE_W-1:VERT_W];
	assign add_ok = ({1'b0, in_a} < lim) && ({1'b0, in_b} < lim) && (cnt_q != FULL_CNT);
	assign mem_we = accept && (s_tuser == CMD_ADD) && add_ok;
	assign rd_addr = (state_q == S_SCAN) ? e_q : '0;

	assign ea     = rd_s1[VERT_W-1:0];
	assign eb     = rd_s1[EDGE_W-1:VERT_W];
	assign e_rng  = ({1'b0, ea} < lim) && ({1'b0, eb} < lim);
	assign take_b = e_rng && ({1'b0, ea} == u_q) && !marked_q[eb];
	assign take_a = e_rng && ({1'b0, eb} == u_q) && !marked_q[ea];
	assign nbr    = take_b ? eb : ea;

	assign cfg_we = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = APB_DW'(vcount_q);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cnt_q[AW-1:0]] <= {in_b, in_a};
		end
		rd_s1 <= mem[rd_addr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_W'(VCOUNT_RST);
		end else if (cfg_we && !paddr[2]) begin
			vcount_q <= pwdata[VCOUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			e_q        <= '0;
			u_q        <= '0;
			marked_q   <= '0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= ST_ACCEPT;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						m_tdata_q <= '0;
						unique case (s_tuser)
							CMD_ADD: begin
								m_tvalid_q <= 1'b1;
								if (add_ok) begin
									cnt_q     <= cnt_q + 1'b1;
									m_tuser_q <= ST_ACCEPT;
								end else begin
									m_tuser_q <= ST_REJECT;
								end
							end
							CMD_COVER: begin
								marked_q <= '0;
								u_q      <= '0;
								state_q  <= S_VCHK;
							end
							CMD_CLEAR: begin
								cnt_q      <= '0;
								m_tvalid_q <= 1'b1;
								m_tuser_q  <= ST_CLEARED;
							end
							default: begin
								m_tvalid_q <= 1'b1;
								m_tuser_q  <= ST_REJECT;
							end
						endcase
					end
				end
				S_VCHK: begin
					if (u_q >= lim) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= marked_q;
						m_tuser_q  <= ST_COVER;
						state_q    <= S_IDLE;
					end else if (marked_q[u_q[VERT_W-1:0]] || (cnt_q == '0)) begin
						u_q <= u_q + 1'b1;
					end else begin
						e_q     <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (e_q < cnt_q) begin
						e_q       <= e_q + 1'b1;
						rd_vld_s1 <= 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
					end
					if (rd_vld_s1 && (take_a || take_b)) begin
						marked_q  <= marked_q | (MASK_W'(1) << nbr)
							| (MASK_W'(1) << u_q[VERT_W-1:0]);
						u_q       <= u_q + 1'b1;
						rd_vld_s1 <= 1'b0;
						state_q   <= S_VCHK;
					end else if (!rd_vld_s1 && (e_q != '0)) begin
						u_q     <= u_q + 1'b1;
						state_q <= S_VCHK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/gvc_checker.sv
`default_nettype none
module gvc_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       s_tvalid,
	input wire logic                       s_tready,
	input wire logic [1:0]                 s_tuser,
	input wire logic                       m_tvalid,
	input wire logic                       m_tready,
	input wire logic [gvc_pkg::MASK_W-1:0] m_tdata,
	input wire logic [1:0]                 m_tuser
);
	import gvc_pkg::*;

	// A stalled result keeps its status and mask.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Only a cover result carries a nonzero mask.
	a_mask_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_COVER) |-> (m_tdata == '0))
		else $error("nonzero mask without cover status");

	// An add answers in the next cycle with accepted or rejected.
	a_add_resp: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == CMD_ADD) |=>
			m_tvalid && ((m_tuser == ST_ACCEPT) || (m_tuser == ST_REJECT)))
		else $error("add transfer without prompt answer");

	// A clear answers in the next cycle with store cleared.
	a_clr_resp: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == CMD_CLEAR) |=>
			m_tvalid && (m_tuser == ST_CLEARED))
		else $error("clear transfer without prompt answer");

endmodule

bind greedy_vertex_cover gvc_checker u_gvc_checker (.*);
`default_nettype wire
